[sv/acsnc_pkg.sv]
// Shared constants and types for the ADC channel smoother / noise calibrator.
// No dependencies; every other file refers to this package by scoped names.
package acsnc_pkg;

  localparam int SAMPLE_LIMIT = 1024;
  localparam int COUNT_W      = $clog2(SAMPLE_LIMIT + 1);

  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 16;
  localparam int THRESH_W = 15;
  localparam int WEIGHT_W = 17;
  localparam int WIDEN_SH = VALUE_W - SAMPLE_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WEIGHT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_OUTPUT = 2'd1;

  // Input operation codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_CAL_START = 1'b1;

  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [THRESH_W-1:0] thresh_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

[sv/acsnc_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on acsnc_pkg for field widths.
interface acsnc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [acsnc_pkg::SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output op, output raw_sample, input ready);
  modport sink   (input valid, input op, input raw_sample, output ready);
endinterface

interface acsnc_out_if;
  logic                 valid;
  logic                 ready;
  acsnc_pkg::value_t    reading;
  logic                 calibrating;
  logic                 calibration_done;
  acsnc_pkg::thresh_t   noise_threshold;

  modport source (output valid, output reading, output calibrating,
                  output calibration_done, output noise_threshold, input ready);
  modport sink   (input valid, input reading, input calibrating,
                  input calibration_done, input noise_threshold, output ready);
endinterface

[sv/acsnc_blend.sv]
// Exponential moving average step: prev + round((x - prev) * w / 2^16).
// Depends on acsnc_pkg for widths; purely combinational, one multiplier.
module acsnc_blend (
  input  acsnc_pkg::value_t  x,
  input  acsnc_pkg::value_t  prev,
  input  acsnc_pkg::weight_t weight,
  output acsnc_pkg::value_t  value
);

  logic signed [acsnc_pkg::VALUE_W:0]                       diff;
  logic signed [acsnc_pkg::WEIGHT_W:0]                      w_s;
  logic signed [acsnc_pkg::VALUE_W+acsnc_pkg::WEIGHT_W+1:0] prod;
  logic signed [acsnc_pkg::VALUE_W+acsnc_pkg::WEIGHT_W+1:0] rounded;

  assign diff    = $signed({1'b0, x}) - $signed({1'b0, prev});
  assign w_s     = $signed({1'b0, weight});
  assign prod    = diff * w_s;
  // Add half an LSB, then floor by taking the bits above the fraction
  assign rounded = prod + $signed((acsnc_pkg::VALUE_W + acsnc_pkg::WEIGHT_W + 2)'(32768));
  assign value   = prev + rounded[2*acsnc_pkg::VALUE_W-1:acsnc_pkg::VALUE_W];

endmodule

[sv/adc_channel_smoother_noise_calibrator.sv]
// ADC channel smoother with noise calibration.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless result_out stalls; the single filter multiply
// and the min/max compares sit between the input register and the result register.
// Reset (rst, synchronous, active high) clears configuration, filter and calibration state.
// Depends on acsnc_pkg, acsnc_if and acsnc_blend.
module adc_channel_smoother_noise_calibrator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [acsnc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [acsnc_pkg::CFG_DATA_W-1:0]       cfg_data,
  acsnc_in_if.sink                               sample_in,
  acsnc_out_if.source                            result_out
);

  // Configuration
  acsnc_pkg::weight_t filter_weight;
  logic               invert_output;

  // Input register
  logic                           s1_valid;
  logic                           s1_op;
  logic [acsnc_pkg::SAMPLE_W-1:0] s1_raw;

  // Channel state
  acsnc_pkg::value_t  current_value, current_value_next;
  logic               cal_active, cal_active_next;
  acsnc_pkg::count_t  cal_count, cal_count_next;
  acsnc_pkg::value_t  noise_max, noise_max_next;
  acsnc_pkg::value_t  noise_min, noise_min_next;
  acsnc_pkg::thresh_t threshold, threshold_next;
  logic               done_next;

  // Result register
  logic               out_valid;
  acsnc_pkg::value_t  out_reading;
  logic               out_calibrating;
  logic               out_done;
  acsnc_pkg::thresh_t out_threshold;

  logic               advance;
  acsnc_pkg::value_t  widened;
  acsnc_pkg::value_t  blended;
  acsnc_pkg::value_t  span;
  logic               filter_on;

  assign advance         = s1_valid && (!out_valid || result_out.ready);
  assign sample_in.ready = !s1_valid || advance;

  assign widened   = {s1_raw, acsnc_pkg::WIDEN_SH'(0)};
  assign filter_on = (filter_weight != '0) && (filter_weight <= acsnc_pkg::WEIGHT_ONE);
  assign span      = noise_max - noise_min;

  acsnc_blend u_blend (
    .x      (widened),
    .prev   (current_value),
    .weight (filter_weight),
    .value  (blended)
  );

  always_comb begin
    current_value_next = current_value;
    cal_active_next    = cal_active;
    cal_count_next     = cal_count;
    noise_max_next     = noise_max;
    noise_min_next     = noise_min;
    threshold_next     = threshold;
    done_next          = 1'b0;
    if (s1_op == acsnc_pkg::OP_CAL_START) begin
      cal_active_next = 1'b1;
      cal_count_next  = '0;
    end else if (cal_active) begin
      // Bypass the filter while calibrating
      current_value_next = widened;
      if (cal_count < acsnc_pkg::COUNT_W'(acsnc_pkg::SAMPLE_LIMIT)) begin
        if (cal_count == '0) begin
          noise_max_next = widened;
          noise_min_next = widened;
        end else if (widened > noise_max) begin
          noise_max_next = widened;
        end else if (widened < noise_min) begin
          noise_min_next = widened;
        end
        cal_count_next = cal_count + 1'b1;
      end else begin
        cal_active_next = 1'b0;
        cal_count_next  = '0;
        threshold_next  = (noise_max >= noise_min) ? span[acsnc_pkg::VALUE_W-1:1] : '0;
        done_next       = 1'b1;
      end
    end else if (filter_on) begin
      current_value_next = blended;
    end else begin
      current_value_next = widened;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight <= '0;
      invert_output <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        acsnc_pkg::CFG_FILTER_WEIGHT: filter_weight <= cfg_data[acsnc_pkg::WEIGHT_W-1:0];
        acsnc_pkg::CFG_INVERT_OUTPUT: invert_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.valid && sample_in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (sample_in.valid && sample_in.ready) begin
      s1_op  <= sample_in.op;
      s1_raw <= sample_in.raw_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_value <= '0;
      cal_active    <= 1'b0;
      cal_count     <= '0;
      noise_max     <= '0;
      noise_min     <= '0;
      threshold     <= '0;
    end else if (advance) begin
      current_value <= current_value_next;
      cal_active    <= cal_active_next;
      cal_count     <= cal_count_next;
      noise_max     <= noise_max_next;
      noise_min     <= noise_min_next;
      threshold     <= threshold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      // 65535 - v is the bitwise complement
      out_reading     <= invert_output ? ~current_value_next : current_value_next;
      out_calibrating <= cal_active_next;
      out_done        <= done_next;
      out_threshold   <= threshold_next;
    end
  end

  assign result_out.valid            = out_valid;
  assign result_out.reading          = out_reading;
  assign result_out.calibrating      = out_calibrating;
  assign result_out.calibration_done = out_done;
  assign result_out.noise_threshold  = out_threshold;

endmodule

[tb/tb_adc_channel_smoother_noise_calibrator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ADC channel smoother and noise calibrator.
// Predicts each result in the bench, then compares with the block's output stream.
// Depends on acsnc_pkg, acsnc_if and the block's RTL.
module tb_adc_channel_smoother_noise_calibrator;

  localparam int RESULT_LATENCY = 2;
  localparam logic [acsnc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [acsnc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [acsnc_pkg::SAMPLE_W-1:0] RAW_MAX = '1;

  typedef struct {
    acsnc_pkg::value_t  reading;
    logic               calibrating;
    logic               done;
    acsnc_pkg::thresh_t threshold;
  } channel_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [acsnc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [acsnc_pkg::CFG_DATA_W-1:0] cfg_data;

  acsnc_in_if  sample_ch();
  acsnc_out_if result_ch();

  adc_channel_smoother_noise_calibrator dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_ch),
    .result_out (result_ch)
  );

  // Channel state as the block should hold it
  acsnc_pkg::weight_t weight_reg;
  logic               invert_reg;
  acsnc_pkg::value_t  level;
  logic               cal_active;
  int                 cal_count;
  acsnc_pkg::value_t  peak_hi;
  acsnc_pkg::value_t  peak_lo;
  acsnc_pkg::thresh_t threshold;

  channel_result_t pending_readings[$];
  channel_result_t want;
  int  error_count;
  int  items_sent;
  int  results_seen;
  int  cal_completions;
  int  stall_left;
  bit  send_idling;
  bit  recv_idling;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_idle(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [acsnc_pkg::SAMPLE_W-1:0] pick_raw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return RAW_MAX;
    return acsnc_pkg::SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  function automatic channel_result_t smooth_and_calibrate(
    input logic                           op,
    input logic [acsnc_pkg::SAMPLE_W-1:0] raw
  );
    channel_result_t r;
    acsnc_pkg::value_t x;
    acsnc_pkg::value_t spread;
    logic [33:0] acc;
    r.done = 1'b0;
    if (op == acsnc_pkg::OP_CAL_START) begin
      cal_active = 1'b1;
      cal_count = 0;
    end else begin
      x = acsnc_pkg::value_t'(raw) << acsnc_pkg::WIDEN_SH;
      if (cal_active) begin
        // filter bypassed for every calibration sample, the closing one too
        level = x;
        if (cal_count < acsnc_pkg::SAMPLE_LIMIT) begin
          if (cal_count == 0) begin
            peak_hi = x;
            peak_lo = x;
          end else if (x > peak_hi) begin
            peak_hi = x;
          end else if (x < peak_lo) begin
            peak_lo = x;
          end
          cal_count++;
        end else begin
          cal_active = 1'b0;
          cal_count = 0;
          spread = peak_hi - peak_lo;
          threshold = spread[acsnc_pkg::VALUE_W-1:1];
          r.done = 1'b1;
          cal_completions++;
        end
      end else if (weight_reg != '0 && weight_reg <= acsnc_pkg::WEIGHT_ONE) begin
        acc = 34'(x) * 34'(weight_reg)
              + 34'(level) * 34'(acsnc_pkg::WEIGHT_ONE - weight_reg)
              + 34'd32768;
        level = acc[31:16];
      end else begin
        level = x;
      end
    end
    r.reading     = invert_reg ? (16'hFFFF - level) : level;
    r.calibrating = cal_active;
    r.threshold   = threshold;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [acsnc_pkg::SAMPLE_W-1:0] raw);
    int gap;
    gap = pick_idle(send_idling);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.op         <= op;
    sample_ch.raw_sample <= raw;
    do @(posedge clk); while (!sample_ch.ready);
    pending_readings.push_back(smooth_and_calibrate(op, raw));
    items_sent++;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_register(input logic [acsnc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [acsnc_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      acsnc_pkg::CFG_FILTER_WEIGHT: weight_reg = data;
      acsnc_pkg::CFG_INVERT_OUTPUT: invert_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic test_directed_edges();
    send_idling = 1'b0;
    recv_idling = 1'b0;
    send_item(acsnc_pkg::OP_SAMPLE, '0);
    send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
    send_item(acsnc_pkg::OP_SAMPLE, 12'hAAA);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h555);
    write_register(acsnc_pkg::CFG_FILTER_WEIGHT,
                   acsnc_pkg::CFG_DATA_W'(acsnc_pkg::WEIGHT_ONE));
    write_register(acsnc_pkg::CFG_INVERT_OUTPUT, 17'd1);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h123);
    send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
    write_register(acsnc_pkg::CFG_FILTER_WEIGHT, 17'd1);
    send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
    send_item(acsnc_pkg::OP_SAMPLE, '0);
    // weight above one disables the filter; spare indexes must do nothing
    write_register(acsnc_pkg::CFG_FILTER_WEIGHT, 17'h10001);
    write_register(CFG_SPARE_LO, 17'h1FFFF);
    write_register(CFG_SPARE_HI, 17'h00001);
    write_register(acsnc_pkg::CFG_INVERT_OUTPUT, 17'h1FFFE);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h800);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h001);
    write_register(acsnc_pkg::CFG_FILTER_WEIGHT, 17'h08000);
    send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
    send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
    send_item(acsnc_pkg::OP_SAMPLE, '0);
    // start ignores its sample; a second start restarts the count
    send_item(acsnc_pkg::OP_CAL_START, RAW_MAX);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h100);
    send_item(acsnc_pkg::OP_CAL_START, 12'h5A5);
    send_item(acsnc_pkg::OP_SAMPLE, 12'h7FF);
  endtask

  task automatic test_full_calibration();
    write_register(acsnc_pkg::CFG_FILTER_WEIGHT,
                   acsnc_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
    write_register(acsnc_pkg::CFG_INVERT_OUTPUT, 17'd1);
    send_idling = 1'b1;
    recv_idling = 1'b1;
    send_item(acsnc_pkg::OP_CAL_START, pick_raw());
    for (int i = 0; i < acsnc_pkg::SAMPLE_LIMIT; i++) begin
      // hold both sides busy through the middle of the run
      send_idling = !(i >= 300 && i < 600);
      recv_idling = !(i >= 400 && i < 700);
      if (i == 311) send_item(acsnc_pkg::OP_SAMPLE, '0);
      else if (i == 707) send_item(acsnc_pkg::OP_SAMPLE, RAW_MAX);
      else send_item(acsnc_pkg::OP_SAMPLE,
                     acsnc_pkg::SAMPLE_W'($urandom_range(0, 4095)));
    end
    send_item(acsnc_pkg::OP_SAMPLE, pick_raw());
    for (int i = 0; i < 30; i++) send_item(acsnc_pkg::OP_SAMPLE, pick_raw());
  endtask

  task automatic test_filter_settings();
    acsnc_pkg::weight_t w;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: w = '0;
        1: w = 17'd1;
        2: w = acsnc_pkg::WEIGHT_ONE;
        3: w = acsnc_pkg::weight_t'($urandom_range(65537, 131071));
        4: w = '1;
        default: w = acsnc_pkg::weight_t'($urandom_range(1, 65535));
      endcase
      write_register(acsnc_pkg::CFG_FILTER_WEIGHT, w);
      write_register(acsnc_pkg::CFG_INVERT_OUTPUT, acsnc_pkg::CFG_DATA_W'($urandom));
      if (phase == 3) write_register(CFG_SPARE_HI, acsnc_pkg::CFG_DATA_W'($urandom));
      send_idling = (phase != 0) && ($urandom_range(0, 3) != 0);
      recv_idling = (phase != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 10; i++) send_item(acsnc_pkg::OP_SAMPLE, pick_raw());
    end
  endtask

  task automatic test_mixed_commands();
    for (int phase = 0; phase < 2; phase++) begin
      write_register(acsnc_pkg::CFG_FILTER_WEIGHT,
                     acsnc_pkg::CFG_DATA_W'($urandom_range(0, 65536)));
      write_register(acsnc_pkg::CFG_INVERT_OUTPUT, acsnc_pkg::CFG_DATA_W'(phase));
      send_idling = 1'b1;
      recv_idling = 1'b1;
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 15) == 0) send_item(acsnc_pkg::OP_CAL_START, pick_raw());
        else send_item(acsnc_pkg::OP_SAMPLE, pick_raw());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (pending_readings.size() == 0) begin
          $error("result with no item outstanding: reading %0d", result_ch.reading);
          error_count++;
        end else begin
          want = pending_readings.pop_front();
          if (result_ch.reading !== want.reading) begin
            $error("reading: expected %0d, got %0d", want.reading, result_ch.reading);
            error_count++;
          end
          if (result_ch.calibrating !== want.calibrating) begin
            $error("calibrating: expected %0b, got %0b", want.calibrating,
                   result_ch.calibrating);
            error_count++;
          end
          if (result_ch.calibration_done !== want.done) begin
            $error("calibration_done: expected %0b, got %0b", want.done,
                   result_ch.calibration_done);
            error_count++;
          end
          if (result_ch.noise_threshold !== want.threshold) begin
            $error("noise_threshold: expected %0d, got %0d", want.threshold,
                   result_ch.noise_threshold);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_idle(recv_idling);
        result_ch.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= acsnc_pkg::CFG_FILTER_WEIGHT;
    cfg_data             <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.op         <= acsnc_pkg::OP_SAMPLE;
    sample_ch.raw_sample <= '0;
    weight_reg      = '0;
    invert_reg      = 1'b0;
    level           = '0;
    cal_active      = 1'b0;
    cal_count       = 0;
    peak_hi         = '0;
    peak_lo         = '0;
    threshold       = '0;
    error_count     = 0;
    items_sent      = 0;
    results_seen    = 0;
    cal_completions = 0;
    send_idling     = 1'b0;
    recv_idling     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_full_calibration();
    test_filter_settings();
    test_mixed_commands();

    drain();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    $display("Sent %0d items and checked %0d results, %0d calibration run(s) completed,",
             items_sent, results_seen, cal_completions);
    $display("across filter weights from off to unity and beyond, with both inversions.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/acsnc_pkg.sv
sv/acsnc_if.sv
sv/acsnc_blend.sv
sv/adc_channel_smoother_noise_calibrator.sv
tb/tb_adc_channel_smoother_noise_calibrator.sv
